[design/txt_pkg.sv]
package txt_pkg;

  localparam int TXT_MAX_DIM   = 1024;
  localparam int TXT_FRAC_BITS = 16;

  localparam int PIX_W   = 10;
  localparam int TICK_W  = 32;
  localparam int BLUE_W  = 8;
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 1;

  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;

  // 765/pi with 16 fractional bits.
  localparam int KQ_W = 24;
  localparam logic [KQ_W-1:0] KQ16 = 24'd15958479;

  // Arctangent of 2^-k, a full turn being 2^32.
  function automatic logic [31:0] txt_atan(input int k);
    logic [31:0] a;
    case (k)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

[design/txt_if.sv]
interface txt_in_if;
  import txt_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;
  logic [TICK_W-1:0] frame_ticks;

  modport source (output valid, output pixel_x, output pixel_y, output frame_ticks,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input frame_ticks,
                output ready);
endinterface

interface txt_out_if;
  import txt_pkg::*;
  logic              valid;
  logic              ready;
  logic [BLUE_W-1:0] texel_blue;
  logic              at_center;

  modport source (output valid, output texel_blue, output at_center, input ready);
  modport sink (input valid, input texel_blue, input at_center, output ready);
endinterface

[design/txt_pipe.sv]
module txt_pipe #(
  parameter int MAX_DIM   = txt_pkg::TXT_MAX_DIM,
  parameter int FRAC_BITS = txt_pkg::TXT_FRAC_BITS,
  parameter int RB        = $clog2(MAX_DIM) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [txt_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [txt_pkg::PIX_W-1:0]  pixel_y_i,
  input  logic [txt_pkg::TICK_W-1:0] ticks_i,
  input  logic [RB-1:0]              width_i,
  input  logic [RB-1:0]              height_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [txt_pkg::BLUE_W-1:0] blue_o,
  output logic                       center_o
);
  import txt_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int DW    = ((RB > PIX_W) ? RB : PIX_W) + 1;
  localparam int R2W   = 2 * DW;
  localparam int PAIRS = DW + F;
  localparam int MW    = PAIRS + 1;
  localparam int NW    = MW + F;
  localparam int QW    = RB + F;
  localparam int CW    = DW + F + 2;
  localparam int TW    = 34;
  localparam int PW    = QW + KQ_W;
  localparam int S_DIV = PAIRS + 2;
  localparam int S_MUL = S_DIV + NW + 1;
  localparam int NS    = S_MUL + 2;

  typedef struct packed {
    logic [8:0]              tk;
    logic                    ctr;
    logic [RB-1:0]           scale;
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic [R2W-1:0]          r2;
    logic [PAIRS-1:0]        root;
    logic [PAIRS+1:0]        srem;
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic signed [TW-1:0]    th;
    logic [7:0]              vb;
    logic                    neg;
    logic [PAIRS+1:0]        drem;
    logic [NW-1:0]           num;
    logic [QW-1:0]           q;
    logic [PW-1:0]           prod;
    logic [BLUE_W-1:0]       blue;
  } rec_t;

  function automatic rec_t stage_fn(input int s, input rec_t a);
    rec_t b;
    int pi;
    logic signed [R2W-1:0] ex, ey;
    logic signed [CW-1:0]  x0, y0, sx, sy;
    logic [1:0]            two;
    logic [PAIRS+1:0]      rm, tr, dr;
    logic [PAIRS-1:0]      sf;
    logic signed [MW:0]    dd;
    logic [MW-1:0]         mg;
    logic [TW-1:0]         ta;
    logic [TW+9:0]         tm;
    logic [7:0]            v8, u8;
    b = a;
    if (s == 1) begin
      ex = R2W'(a.dx);
      ey = R2W'(a.dy);
      b.r2 = $unsigned(ex * ex + ey * ey);
      b.root = '0;
      b.srem = '0;
      x0 = CW'(a.dx) <<< F;
      y0 = CW'(a.dy) <<< F;
      if (x0 < 0) begin
        if (y0 >= 0) begin
          b.cx = y0;
          b.cy = -x0;
          b.th = TW'(1) <<< 30;
        end else begin
          b.cx = -y0;
          b.cy = x0;
          b.th = -(TW'(1) <<< 30);
        end
      end else begin
        b.cx = x0;
        b.cy = y0;
        b.th = '0;
      end
    end else if (s >= 2 && s < S_DIV) begin
      pi = PAIRS - 1 - (s - 2);
      if (pi >= F) begin
        two = 2'(a.r2 >> (2 * (pi - F)));
      end else begin
        two = 2'b00;
      end
      rm = {a.srem[PAIRS-1:0], two};
      tr = {a.root, 2'b01};
      if (rm >= tr) begin
        b.srem = rm - tr;
        b.root = {a.root[PAIRS-2:0], 1'b1};
      end else begin
        b.srem = rm;
        b.root = {a.root[PAIRS-2:0], 1'b0};
      end
      if (s - 2 < F) begin
        sx = a.cx >>> (s - 2);
        sy = a.cy >>> (s - 2);
        if (a.cy > 0) begin
          b.cx = a.cx + sy;
          b.cy = a.cy - sx;
          b.th = a.th + $signed({2'b00, txt_atan(s - 2)});
        end else begin
          b.cx = a.cx - sy;
          b.cy = a.cy + sx;
          b.th = a.th - $signed({2'b00, txt_atan(s - 2)});
        end
      end
    end else if (s == S_DIV) begin
      sf = PAIRS'(a.scale) << F;
      dd = $signed({2'b00, a.root}) - $signed({2'b00, sf});
      b.neg = dd[MW];
      mg = dd[MW] ? MW'(-dd) : MW'(dd);
      b.num = {mg, F'(0)};
      b.drem = '0;
      b.q = '0;
      ta = a.th[TW-1] ? $unsigned(-a.th) : $unsigned(a.th);
      tm = (TW+10)'(ta) * (TW+10)'(765);
      v8 = tm[31 +: 8];
      b.vb = a.th[TW-1] ? 8'(-v8) : v8;
    end else if (s > S_DIV && s < S_MUL) begin
      dr = {a.drem[PAIRS:0], a.num[NW-1]};
      b.num = {a.num[NW-2:0], 1'b0};
      if (dr >= {2'b00, a.root}) begin
        b.drem = dr - {2'b00, a.root};
        b.q = {a.q[QW-2:0], 1'b1};
      end else begin
        b.drem = dr;
        b.q = {a.q[QW-2:0], 1'b0};
      end
    end else if (s == S_MUL) begin
      b.prod = PW'(a.q) * PW'(KQ16);
    end else if (s == S_MUL + 1) begin
      u8 = a.prod[F+16 +: 8];
      if (a.neg) begin
        u8 = 8'(-u8);
      end
      v8 = a.vb;
      if (a.ctr) begin
        u8 = '0;
        v8 = '0;
      end
      b.blue = 8'(u8 + a.tk[7:0]) ^ 8'(v8 + a.tk[8:1]);
    end
    return b;
  endfunction

  rec_t          pipe_q [NS];
  rec_t          nxt    [NS];
  logic [NS-1:0] vld_q;
  logic          en;
  logic [RB-1:0] big;

  assign en          = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];
  assign blue_o      = pipe_q[NS-1].blue;
  assign center_o    = pipe_q[NS-1].ctr;
  assign big         = (width_i > height_i) ? width_i : height_i;

  always_comb begin
    nxt[0] = '0;
    nxt[0].tk = ticks_i[8:0];
    nxt[0].dx = $signed(DW'(pixel_x_i)) - $signed(DW'(width_i >> 1));
    nxt[0].dy = $signed(DW'(pixel_y_i)) - $signed(DW'(height_i >> 1));
    nxt[0].ctr = (nxt[0].dx == 0) && (nxt[0].dy == 0);
    nxt[0].scale = (big == '0) ? '0 : big - RB'(1);
    for (int s = 1; s < NS; s++) begin
      nxt[s] = stage_fn(s, pipe_q[s-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && in_valid_i |=> vld_q[0])
    else $error("accepted transfer did not enter the pipeline");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_DIV-1] && !pipe_q[S_DIV-1].ctr |-> pipe_q[S_DIV-1].root[PAIRS-1:F] != '0)
    else $error("radius below one pixel off the center");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_MUL-1] && !pipe_q[S_MUL-1].ctr |->
      pipe_q[S_MUL-1].drem < {2'b00, pipe_q[S_MUL-1].root})
    else $error("division remainder not below the radius");

endmodule

[design/tunnel_xor_texel.sv]
// Channel  Direction  Payload
// pix_i    in         pixel_x, pixel_y, frame_ticks
// tex_o    out        texel_blue, at_center
// cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i (width, height)
//
// One pixel is taken every cycle while the output is not stalled. The pipeline
// is mostly the digit-per-stage square root followed by the bit-per-stage radius
// divide; the CORDIC runs alongside the root.
// Reset clears the valid bits and loads width 320 and height 240.
// A stall on the output freezes every stage, so no transfer is lost or repeated.
module tunnel_xor_texel #(
  parameter int MAX_DIM   = txt_pkg::TXT_MAX_DIM,
  parameter int FRAC_BITS = txt_pkg::TXT_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [txt_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [txt_pkg::CFG_W-1:0]  cfg_data_i,
  txt_in_if.sink                     pix_i,
  txt_out_if.source                  tex_o
);
  import txt_pkg::*;

  localparam int RB = $clog2(MAX_DIM) + 1;
  localparam int CMPW = (RB > CFG_W) ? RB : CFG_W;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CMPW-1:0]  wx, hx;
  logic [RB-1:0]    w_sat, h_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wx    = CMPW'(width_q);
  assign hx    = CMPW'(height_q);
  assign w_sat = (wx > CMPW'(MAX_DIM)) ? RB'(MAX_DIM) : RB'(wx);
  assign h_sat = (hx > CMPW'(MAX_DIM)) ? RB'(MAX_DIM) : RB'(hx);

  txt_pipe #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .RB        (RB)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .pixel_x_i   (pix_i.pixel_x),
    .pixel_y_i   (pix_i.pixel_y),
    .ticks_i     (pix_i.frame_ticks),
    .width_i     (w_sat),
    .height_i    (h_sat),
    .out_valid_o (tex_o.valid),
    .out_ready_i (tex_o.ready),
    .blue_o      (tex_o.texel_blue),
    .center_o    (tex_o.at_center)
  );

endmodule
